FILE: hw/rtl/tapid_pkg.sv
package tapid_pkg;

    // Field widths
    localparam int ALT_W = 20;
    localparam int SPD_W = 13;
    localparam int HDG_W = 15;
    localparam int DT_W = 13;
    localparam int CLIMB_W = 16;
    localparam int ACCEL_W = 9;
    localparam int TURN_W = 11;
    localparam int CMD_W = 16;

    // Configuration port
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_TALT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TSPD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THDG = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ENG = 3'd4;
    localparam logic [DT_W-1:0] TICK_RESET = 13'd1024;

    // Datapath widths
    localparam int ERR_W = 24;
    localparam int INT_W = 32;
    localparam int ISUM_W = 46;
    localparam int OPA_W = 27;
    localparam int OPB_W = 18;
    localparam int PROD_W = OPA_W + OPB_W;
    localparam int ACC_W = 60;
    localparam int Q_SH = 26;
    localparam int DER_SH = 21;
    localparam int DIVN_W = 58;
    localparam int DIVM_W = DIVN_W - 1;
    localparam int DIVD_W = 17;
    localparam int DCNT_W = $clog2(DIVM_W + 1);

    // Physical constants
    localparam int ALT_MAX = 800000;
    localparam int SPD_MAX = 8000;
    localparam int HDG_FULL = 23040;
    localparam int HDG_HALF = 11520;
    localparam int ALT_DIV = 61440;
    localparam int SPD_RND = 512;
    localparam int RATE_SH = 10;

    // Altitude step: floor((x + 30720) / 4096), then divide by 15 by reciprocal
    localparam int ALT_RND = 30720;
    localparam int ALT_PRE_SH = 12;
    localparam int ALT_QBIAS = 4370;
    localparam int ALT_UBIAS = 65550;    // 15 * ALT_QBIAS keeps the dividend positive
    localparam int AQ_W = 18;
    localparam int ALT_REC = 279621;     // ceil(2^22 / 15)
    localparam int ALT_REC_SH = 22;
    localparam int AQP_W = 37;

    // Datapath operations
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NOP = 4'd0;
    localparam logic [OP_W-1:0] OP_ERR = 4'd1;
    localparam logic [OP_W-1:0] OP_MEDT = 4'd2;
    localparam logic [OP_W-1:0] OP_INT = 4'd3;
    localparam logic [OP_W-1:0] OP_P = 4'd4;
    localparam logic [OP_W-1:0] OP_I = 4'd5;
    localparam logic [OP_W-1:0] OP_DST = 4'd6;
    localparam logic [OP_W-1:0] OP_D = 4'd7;
    localparam logic [OP_W-1:0] OP_OUT = 4'd8;
    localparam logic [OP_W-1:0] OP_MC = 4'd9;
    localparam logic [OP_W-1:0] OP_NAS = 4'd10;
    localparam logic [OP_W-1:0] OP_NS = 4'd11;
    localparam logic [OP_W-1:0] OP_NH = 4'd12;
    localparam logic [OP_W-1:0] OP_NA = 4'd13;
    localparam logic [OP_W-1:0] OP_FIN = 4'd14;

    // Loop numbers
    localparam logic [1:0] LOOP_ALT = 2'd0;
    localparam logic [1:0] LOOP_SPD = 2'd1;
    localparam logic [1:0] LOOP_HDG = 2'd2;

    typedef struct packed {
        logic            in_load;
        logic [OP_W-1:0] op;
        logic [1:0]      loop;
    } tapid_cmd_t;

    typedef struct packed {
        logic engaged;
        logic first_tick;
        logic div_busy;
        logic div_done;
    } tapid_stat_t;

    // Q16 gains
    function automatic logic signed [OPB_W-1:0] kp_of(input logic [1:0] k);
        case (k)
            LOOP_ALT: kp_of = 18'sd22938;
            LOOP_SPD: kp_of = 18'sd78643;
            default:  kp_of = 18'sd32768;
        endcase
    endfunction

    function automatic logic signed [OPB_W-1:0] ki_of(input logic [1:0] k);
        case (k)
            LOOP_ALT: ki_of = 18'sd655;
            LOOP_SPD: ki_of = 18'sd3277;
            default:  ki_of = 18'sd0;
        endcase
    endfunction

    function automatic logic signed [OPB_W-1:0] kd_of(input logic [1:0] k);
        case (k)
            LOOP_ALT: kd_of = 18'sd7864;
            LOOP_SPD: kd_of = 18'sd6554;
            default:  kd_of = 18'sd9830;
        endcase
    endfunction

    // Integrator limit, error unit times 1/1024 s
    function automatic logic signed [ISUM_W-1:0] ilim_of(input logic [1:0] k);
        case (k)
            LOOP_HDG: ilim_of = 46'sd32768000;
            default:  ilim_of = 46'sd8192000;
        endcase
    endfunction

    // Command limit in Q26
    function automatic logic signed [ACC_W-1:0] olim_of(input logic [1:0] k);
        case (k)
            LOOP_ALT: olim_of = 60'sd32000 <<< Q_SH;
            LOOP_SPD: olim_of = 60'sd240 <<< Q_SH;
            default:  olim_of = 60'sd640 <<< Q_SH;
        endcase
    endfunction

endpackage

FILE: hw/rtl/tapid_div.sv
module tapid_div
    import tapid_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [DIVN_W-1:0] num,
    input  logic [DIVD_W-1:0]        den,
    output logic                     busy,
    output logic                     done,
    output logic signed [DIVN_W-1:0] quo
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic              neg_reg, neg_next;
    logic [DIVM_W-1:0] sh_reg, sh_next;
    logic [DIVD_W-1:0] rem_reg, rem_next;
    logic [DIVD_W-1:0] den_reg, den_next;
    logic [DIVD_W:0]   rem_sh;
    logic [DIVD_W:0]   rem_sub;

    // One quotient bit per cycle, restoring; negative numerators use ~N
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        neg_next = neg_reg;
        sh_next = sh_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        rem_sh = {rem_reg, sh_reg[DIVM_W-1]};
        rem_sub = rem_sh - {1'b0, den_reg};
        if (start) begin
            busy_next = 1'b1;
            cnt_next = DCNT_W'(DIVM_W);
            neg_next = num[DIVN_W-1];
            sh_next = num[DIVN_W-1] ? ~num[DIVM_W-1:0] : num[DIVM_W-1:0];
            rem_next = '0;
            den_next = den;
        end else if (busy_reg) begin
            if (!rem_sub[DIVD_W]) begin
                rem_next = rem_sub[DIVD_W-1:0];
                sh_next = {sh_reg[DIVM_W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[DIVD_W-1:0];
                sh_next = {sh_reg[DIVM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        neg_reg <= neg_next;
        sh_reg <= sh_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo = neg_reg ? ~$signed({1'b0, sh_reg}) : $signed({1'b0, sh_reg});

endmodule

FILE: hw/rtl/tapid_datapath.sv
module tapid_datapath
    import tapid_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  tapid_cmd_t                cmd,
    output tapid_stat_t               stat,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic [ALT_W-1:0]          in_alt,
    input  logic [SPD_W-1:0]          in_spd,
    input  logic [HDG_W-1:0]          in_hdg,
    output logic signed [CLIMB_W-1:0] out_climb,
    output logic signed [ACCEL_W-1:0] out_accel,
    output logic signed [TURN_W-1:0]  out_turn,
    output logic [ALT_W-1:0]          out_alt,
    output logic [SPD_W-1:0]          out_spd,
    output logic [HDG_W-1:0]          out_hdg,
    output logic                      out_active
);

    // Configuration and loop state
    logic [ALT_W-1:0]        talt_reg;
    logic [SPD_W-1:0]        tspd_reg;
    logic [HDG_W-1:0]        thdg_reg;
    logic [DT_W-1:0]         tick_reg;
    logic                    eng_reg;
    logic signed [INT_W-1:0] integ_reg [3];
    logic signed [ERR_W-1:0] prev_reg [3];
    logic                    first_reg;

    // Working registers
    logic [ALT_W-1:0]         alt_reg;
    logic [SPD_W-1:0]         spd_reg;
    logic [HDG_W-1:0]         hdg_reg;
    logic signed [ERR_W-1:0]  e_reg;
    logic signed [OPA_W-1:0]  i_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [CMD_W-1:0]  cmdv_reg [3];
    logic [ALT_W-1:0]         na_reg;
    logic [SPD_W-1:0]         ns_reg;
    logic [HDG_W-1:0]         nh_reg;
    logic [AQ_W-1:0]          aq_reg;

    // Result registers
    logic signed [CLIMB_W-1:0] oclimb_reg;
    logic signed [ACCEL_W-1:0] oaccel_reg;
    logic signed [TURN_W-1:0]  oturn_reg;
    logic [ALT_W-1:0]          oalt_reg;
    logic [SPD_W-1:0]          ospd_reg;
    logic [HDG_W-1:0]          ohdg_reg;
    logic                      oact_reg;

    logic [DT_W-1:0]          dt_eff;
    logic signed [ERR_W-1:0]  err_sel;
    logic [17:0]              hv, hw;
    logic signed [OPA_W-1:0]  diff;
    logic signed [OPA_W-1:0]  mul_a;
    logic signed [OPB_W-1:0]  mul_b;
    logic signed [OPB_W-1:0]  dt_op;
    logic signed [ISUM_W-1:0] isum, ilim, iclamp;
    logic signed [ACC_W-1:0]  olim, aclamp, around;
    logic                     div_start;
    logic signed [DIVN_W-1:0] div_num, div_q;
    logic [DIVD_W-1:0]        div_den;
    logic                     div_busy, div_done;
    logic signed [31:0]       rate_t, nsum, nhsum, nasum;
    logic signed [31:0]       ysum;
    logic [AQP_W-1:0]         aq_prod;
    logic [SPD_W-1:0]         ns_val;
    logic [HDG_W-1:0]         nh_val;
    logic [ALT_W-1:0]         na_val;
    logic                     cfg_hit;

    assign dt_eff = (tick_reg == '0) ? DT_W'(1) : tick_reg;
    assign dt_op = OPB_W'($signed({1'b0, dt_eff}));
    assign cfg_hit = cfg_we && (cfg_index inside {[CFG_TALT:CFG_ENG]});

    // Loop error; heading takes the short way round
    always_comb begin
        hv = 18'(thdg_reg) - 18'(hdg_reg) + 18'(HDG_FULL + HDG_HALF);
        if (hv >= 18'(2 * HDG_FULL)) begin
            hw = hv - 18'(2 * HDG_FULL);
        end else if (hv >= 18'(HDG_FULL)) begin
            hw = hv - 18'(HDG_FULL);
        end else begin
            hw = hv;
        end
        case (cmd.loop)
            LOOP_ALT: err_sel = ERR_W'($signed({1'b0, talt_reg}))
                - ERR_W'($signed({1'b0, alt_reg}));
            LOOP_SPD: err_sel = ERR_W'($signed({1'b0, tspd_reg}))
                - ERR_W'($signed({1'b0, spd_reg}));
            default:  err_sel = ERR_W'($signed({1'b0, hw})) - ERR_W'(HDG_HALF);
        endcase
    end

    assign diff = OPA_W'(e_reg) - OPA_W'(prev_reg[cmd.loop]);

    // Shared multiplier operand select
    always_comb begin
        case (cmd.op)
            OP_INT: begin
                mul_a = OPA_W'(e_reg);
                mul_b = kp_of(cmd.loop);
            end
            OP_P: begin
                mul_a = i_reg;
                mul_b = ki_of(cmd.loop);
            end
            OP_I: begin
                mul_a = diff;
                mul_b = kd_of(cmd.loop);
            end
            OP_MC: begin
                mul_a = OPA_W'(cmdv_reg[0]);
                mul_b = dt_op;
            end
            OP_NAS: begin
                mul_a = OPA_W'(cmdv_reg[1]);
                mul_b = dt_op;
            end
            OP_NS: begin
                mul_a = OPA_W'(cmdv_reg[2]);
                mul_b = dt_op;
            end
            default: begin
                mul_a = OPA_W'(e_reg);
                mul_b = dt_op;
            end
        endcase
    end

    // Integrator clamp and command clamp with rounding
    always_comb begin
        isum = ISUM_W'(integ_reg[cmd.loop]) + ISUM_W'(prod_reg);
        ilim = ilim_of(cmd.loop);
        if (isum > ilim) begin
            iclamp = ilim;
        end else if (isum < -ilim) begin
            iclamp = -ilim;
        end else begin
            iclamp = isum;
        end
        olim = olim_of(cmd.loop);
        if (acc_reg > olim) begin
            aclamp = olim;
        end else if (acc_reg < -olim) begin
            aclamp = -olim;
        end else begin
            aclamp = acc_reg;
        end
        around = aclamp + (ACC_W'(1) <<< (Q_SH - 1));
    end

    // Divider operands: derivative term over the tick period
    always_comb begin
        div_start = (cmd.op == OP_DST);
        div_num = (DIVN_W'(prod_reg) <<< DER_SH) + DIVN_W'($signed({1'b0, dt_eff}));
        div_den = DIVD_W'({dt_eff, 1'b0});
    end

    tapid_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .done    (div_done),
        .quo     (div_q)
    );

    // Integrate the commands over one tick
    always_comb begin
        rate_t = (32'(prod_reg) + 32'sd512) >>> RATE_SH;
        nsum = 32'($signed({1'b0, spd_reg})) + rate_t;
        if (nsum < 0) begin
            ns_val = '0;
        end else if (nsum > SPD_MAX) begin
            ns_val = SPD_W'(SPD_MAX);
        end else begin
            ns_val = nsum[SPD_W-1:0];
        end
        nhsum = 32'($signed({1'b0, hdg_reg})) + rate_t;
        if (nhsum < 0) begin
            nh_val = HDG_W'(nhsum + HDG_FULL);
        end else if (nhsum >= HDG_FULL) begin
            nh_val = HDG_W'(nhsum - HDG_FULL);
        end else begin
            nh_val = nhsum[HDG_W-1:0];
        end
        // altitude step: biased coarse quotient, then divide by 15
        ysum = 32'(prod_reg) + 32'(ALT_RND);
        aq_prod = AQP_W'(aq_reg) * AQP_W'(ALT_REC);
        nasum = 32'($signed({1'b0, alt_reg}))
            + 32'($signed({1'b0, aq_prod[AQP_W-1:ALT_REC_SH]})) - 32'(ALT_QBIAS);
        if (nasum < 0) begin
            na_val = '0;
        end else if (nasum > ALT_MAX) begin
            na_val = ALT_W'(ALT_MAX);
        end else begin
            na_val = nasum[ALT_W-1:0];
        end
    end

    // Configuration and loop state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            talt_reg <= '0;
            tspd_reg <= '0;
            thdg_reg <= '0;
            tick_reg <= TICK_RESET;
            eng_reg <= 1'b0;
            first_reg <= 1'b1;
            for (int k = 0; k < 3; k++) begin
                integ_reg[k] <= '0;
                prev_reg[k] <= '0;
            end
        end else if (cfg_hit) begin
            case (cfg_index)
                CFG_TALT: talt_reg <= cfg_data[ALT_W-1:0];
                CFG_TSPD: tspd_reg <= cfg_data[SPD_W-1:0];
                CFG_THDG: thdg_reg <= cfg_data[HDG_W-1:0];
                CFG_TICK: tick_reg <= cfg_data[DT_W-1:0];
                default:  eng_reg <= cfg_data[0];
            endcase
            first_reg <= 1'b1;
            for (int k = 0; k < 3; k++) begin
                integ_reg[k] <= '0;
                prev_reg[k] <= '0;
            end
        end else begin
            if (cmd.op == OP_INT) begin
                integ_reg[cmd.loop] <= INT_W'(iclamp);
            end
            if (cmd.op == OP_OUT) begin
                prev_reg[cmd.loop] <= e_reg;
            end
            if (cmd.op == OP_FIN && eng_reg) begin
                first_reg <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            alt_reg <= in_alt;
            spd_reg <= in_spd;
            hdg_reg <= in_hdg;
        end
        prod_reg <= mul_a * mul_b;
        case (cmd.op)
            OP_ERR: e_reg <= err_sel;
            OP_INT: i_reg <= OPA_W'(iclamp);
            OP_P:   acc_reg <= ACC_W'(prod_reg) <<< RATE_SH;
            OP_I:   acc_reg <= acc_reg + ACC_W'(prod_reg);
            OP_D:   acc_reg <= acc_reg + ACC_W'(div_q);
            OP_OUT: cmdv_reg[cmd.loop] <= around[CMD_W+Q_SH-1:Q_SH];
            OP_NAS: aq_reg <= AQ_W'((ysum >>> ALT_PRE_SH) + ALT_UBIAS);
            OP_NS:  ns_reg <= ns_val;
            OP_NH:  nh_reg <= nh_val;
            OP_NA:  na_reg <= na_val;
            default: ;
        endcase
    end

    // Result registers
    always_ff @(posedge aclk) begin
        if (cmd.op == OP_FIN) begin
            if (eng_reg) begin
                oclimb_reg <= cmdv_reg[0];
                oaccel_reg <= ACCEL_W'(cmdv_reg[1]);
                oturn_reg <= TURN_W'(cmdv_reg[2]);
                oalt_reg <= na_reg;
                ospd_reg <= ns_reg;
                ohdg_reg <= nh_reg;
                oact_reg <= 1'b1;
            end else begin
                oclimb_reg <= '0;
                oaccel_reg <= '0;
                oturn_reg <= '0;
                oalt_reg <= alt_reg;
                ospd_reg <= spd_reg;
                ohdg_reg <= hdg_reg;
                oact_reg <= 1'b0;
            end
        end
    end

    assign out_climb = oclimb_reg;
    assign out_accel = oaccel_reg;
    assign out_turn = oturn_reg;
    assign out_alt = oalt_reg;
    assign out_spd = ospd_reg;
    assign out_hdg = ohdg_reg;
    assign out_active = oact_reg;

    assign stat.engaged = eng_reg;
    assign stat.first_tick = first_reg;
    assign stat.div_busy = div_busy;
    assign stat.div_done = div_done;

endmodule

FILE: hw/rtl/tapid_ctrl.sv
module tapid_ctrl
    import tapid_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    input  tapid_stat_t stat,
    output tapid_cmd_t  cmd
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_ERR   = 5'd1;
    localparam logic [4:0] S_MEDT  = 5'd2;
    localparam logic [4:0] S_INT   = 5'd3;
    localparam logic [4:0] S_P     = 5'd4;
    localparam logic [4:0] S_I     = 5'd5;
    localparam logic [4:0] S_DST   = 5'd6;
    localparam logic [4:0] S_DWAIT = 5'd7;
    localparam logic [4:0] S_D     = 5'd8;
    localparam logic [4:0] S_OUT   = 5'd9;
    localparam logic [4:0] S_MC    = 5'd10;
    localparam logic [4:0] S_NAS   = 5'd11;
    localparam logic [4:0] S_NS    = 5'd12;
    localparam logic [4:0] S_NH    = 5'd13;
    localparam logic [4:0] S_NA    = 5'd15;
    localparam logic [4:0] S_FIN   = 5'd16;

    logic [4:0] state_reg, state_next;
    logic [1:0] loop_reg, loop_next;
    logic       mv_reg, mv_next;
    logic       accept;
    logic       fin_go;

    assign s_ready = (state_reg == S_IDLE);
    assign accept = s_valid && s_ready;
    assign fin_go = (state_reg == S_FIN) && (!mv_reg || m_ready);

    // Sequence the three loops, then the state integration
    always_comb begin
        state_next = state_reg;
        loop_next = loop_reg;
        cmd.in_load = accept;
        cmd.loop = loop_reg;
        cmd.op = OP_NOP;
        case (state_reg)
            S_IDLE: begin
                loop_next = LOOP_ALT;
                if (accept) begin
                    state_next = stat.engaged ? S_ERR : S_FIN;
                end
            end
            S_ERR: begin
                cmd.op = OP_ERR;
                state_next = S_MEDT;
            end
            S_MEDT: begin
                cmd.op = OP_MEDT;
                state_next = S_INT;
            end
            S_INT: begin
                cmd.op = OP_INT;
                state_next = S_P;
            end
            S_P: begin
                cmd.op = OP_P;
                state_next = S_I;
            end
            S_I: begin
                cmd.op = OP_I;
                state_next = stat.first_tick ? S_OUT : S_DST;
            end
            S_DST: begin
                cmd.op = OP_DST;
                state_next = S_DWAIT;
            end
            S_DWAIT: begin
                if (stat.div_done) begin
                    state_next = S_D;
                end
            end
            S_D: begin
                cmd.op = OP_D;
                state_next = S_OUT;
            end
            S_OUT: begin
                cmd.op = OP_OUT;
                if (loop_reg == LOOP_HDG) begin
                    state_next = S_MC;
                end else begin
                    loop_next = loop_reg + 1'b1;
                    state_next = S_ERR;
                end
            end
            S_MC: begin
                cmd.op = OP_MC;
                state_next = S_NAS;
            end
            S_NAS: begin
                cmd.op = OP_NAS;
                state_next = S_NS;
            end
            S_NS: begin
                cmd.op = OP_NS;
                state_next = S_NH;
            end
            S_NH: begin
                cmd.op = OP_NH;
                state_next = S_NA;
            end
            S_NA: begin
                cmd.op = OP_NA;
                state_next = S_FIN;
            end
            S_FIN: begin
                if (fin_go) begin
                    cmd.op = OP_FIN;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Hold the result until taken; a new result wins over the drop
    always_comb begin
        mv_next = mv_reg;
        if (fin_go) begin
            mv_next = 1'b1;
        end else if (m_ready) begin
            mv_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            loop_reg <= LOOP_ALT;
            mv_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            loop_reg <= loop_next;
            mv_reg <= mv_next;
        end
    end

    assign m_valid = mv_reg;

    a_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_DST) |-> !stat.div_busy)
        else $error("divider started while busy");

    a_fin_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_FIN) |=> m_valid)
        else $error("result not presented after finish");

    a_load_start: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.in_load |=> (state_reg == S_ERR || state_reg == S_FIN))
        else $error("accepted item did not start processing");

    a_wait_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DWAIT && !stat.div_done) |-> stat.div_busy)
        else $error("waiting on an idle divider");

endmodule

FILE: hw/rtl/three_axis_pid_hold_controller.sv
// Three-axis altitude, airspeed and heading hold: three PID loops sharing one
// tick period, with integrator clamping and command limiting.
//
// Channels: s_* takes one item of measured altitude, speed and heading; m_*
// returns one result item per input item (three commands, the integrated next
// altitude, speed and heading, and loops_active). cfg_* writes the setpoints,
// tick period and engage bit; any write to a valid index clears the loop
// state. cfg_ready is always high; write only while the block is idle.
//
// Disengaged, an accepted item goes straight to the finish state. Engaged, the
// first tick after a clear skips the derivative term; later ticks wait on the
// bit-serial divide of each loop's derivative term by the tick period. One
// item is in work at a time; the next is taken once the result is registered.
//
// Reset: setpoints 0, tick period 1024, disengaged, loop state cleared.
// If the receiver stalls, the result holds in the output register; a new item
// may be accepted and worked, finishing only once the held result is taken.
module three_axis_pid_hold_controller
    import tapid_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [ALT_W-1:0]          s_measured_altitude,
    input  logic [SPD_W-1:0]          s_measured_speed,
    input  logic [HDG_W-1:0]          s_measured_heading,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [CLIMB_W-1:0] m_climb_command,
    output logic signed [ACCEL_W-1:0] m_accel_command,
    output logic signed [TURN_W-1:0]  m_turn_command,
    output logic [ALT_W-1:0]          m_next_altitude,
    output logic [SPD_W-1:0]          m_next_speed,
    output logic [HDG_W-1:0]          m_next_heading,
    output logic                      m_loops_active,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data
);

    tapid_cmd_t  cmd;
    tapid_stat_t stat;

    assign cfg_ready = 1'b1;

    tapid_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    tapid_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_we     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_alt     (s_measured_altitude),
        .in_spd     (s_measured_speed),
        .in_hdg     (s_measured_heading),
        .out_climb  (m_climb_command),
        .out_accel  (m_accel_command),
        .out_turn   (m_turn_command),
        .out_alt    (m_next_altitude),
        .out_spd    (m_next_speed),
        .out_hdg    (m_next_heading),
        .out_active (m_loops_active)
    );

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top
    import tapid_pkg::*;
();

    // One result item of the block
    typedef struct packed {
        logic signed [CLIMB_W-1:0] climb;
        logic signed [ACCEL_W-1:0] accel;
        logic signed [TURN_W-1:0]  turn;
        logic [ALT_W-1:0]          alt;
        logic [SPD_W-1:0]          spd;
        logic [HDG_W-1:0]          hdg;
        logic                      active;
    } hold_result_t;

    // One row of the directed script: a register write or a measurement item
    typedef struct packed {
        logic                   is_write;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
        logic [ALT_W-1:0]       alt;
        logic [SPD_W-1:0]       spd;
        logic [HDG_W-1:0]       hdg;
        logic                   typed;
        hold_result_t           want;
    } script_row_t;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int STALL_CYCLES = 1500;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 106;

    // Loop gains in Q16, integrator and command limits
    localparam longint KP[3] = '{22938, 78643, 32768};
    localparam longint KI[3] = '{655, 3277, 0};
    localparam longint KD[3] = '{7864, 6554, 9830};
    localparam longint ILIM[3] = '{8192000, 8192000, 32768000};
    localparam longint OLIM[3] = '{32000, 240, 640};
    localparam longint Q26 = 64'd67108864;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic [ALT_W-1:0]          s_measured_altitude;
    logic [SPD_W-1:0]          s_measured_speed;
    logic [HDG_W-1:0]          s_measured_heading;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [CLIMB_W-1:0] m_climb_command;
    logic signed [ACCEL_W-1:0] m_accel_command;
    logic signed [TURN_W-1:0]  m_turn_command;
    logic [ALT_W-1:0]          m_next_altitude;
    logic [SPD_W-1:0]          m_next_speed;
    logic [HDG_W-1:0]          m_next_heading;
    logic                      m_loops_active;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;

    three_axis_pid_hold_controller u_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_measured_altitude (s_measured_altitude),
        .s_measured_speed    (s_measured_speed),
        .s_measured_heading  (s_measured_heading),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_climb_command     (m_climb_command),
        .m_accel_command     (m_accel_command),
        .m_turn_command      (m_turn_command),
        .m_next_altitude     (m_next_altitude),
        .m_next_speed        (m_next_speed),
        .m_next_heading      (m_next_heading),
        .m_loops_active      (m_loops_active),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    // Controller copy: setpoints, tick and loop state
    logic [ALT_W-1:0] hold_alt;
    logic [SPD_W-1:0] hold_spd;
    logic [HDG_W-1:0] hold_hdg;
    logic [DT_W-1:0]  hold_tick;
    logic             hold_engaged;
    longint           integ[3];
    longint           last_err[3];
    bit               fresh_loops;

    hold_result_t expected_results[$];
    script_row_t  script[$];
    int           fail_count;
    int           results_seen;
    bit           calm;
    bit           run_started;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic longint floor_quot(input longint n, input longint d);
        longint q;
        q = n / d;
        if ((n % d) < 0) q = q - 1;
        return q;
    endfunction

    function automatic longint nearest_quot(input longint n, input longint d);
        return floor_quot(2 * n + d, 2 * d);
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void clear_loops();
        for (int k = 0; k < 3; k++) begin
            integ[k] = 0;
            last_err[k] = 0;
        end
        fresh_loops = 1'b1;
    endfunction

    function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_TALT: hold_alt = data[ALT_W-1:0];
            CFG_TSPD: hold_spd = data[SPD_W-1:0];
            CFG_THDG: hold_hdg = data[HDG_W-1:0];
            CFG_TICK: hold_tick = data[DT_W-1:0];
            CFG_ENG:  hold_engaged = data[0];
            default:  return;
        endcase
        clear_loops();
    endfunction

    // One PID loop: integrate, sum P+I+D in Q26, clamp, round to command unit
    function automatic longint pid_command(input int k, input longint e, input longint dt);
        longint acc;
        longint lim;
        integ[k] = clip(integ[k] + e * dt, -ILIM[k], ILIM[k]);
        acc = KP[k] * e * 1024 + KI[k] * integ[k];
        if (!fresh_loops)
            acc = acc + nearest_quot(KD[k] * (e - last_err[k]) * 1048576, dt);
        last_err[k] = e;
        lim = OLIM[k] * Q26;
        return nearest_quot(clip(acc, -lim, lim), Q26);
    endfunction

    function automatic hold_result_t predict_tick(input logic [ALT_W-1:0] a,
                                                  input logic [SPD_W-1:0] s,
                                                  input logic [HDG_W-1:0] h);
        hold_result_t r;
        longint dt, climb, accel, turn, herr, na, ns, nh;
        if (!hold_engaged) begin
            r = '0;
            r.alt = a;
            r.spd = s;
            r.hdg = h;
            return r;
        end
        dt = (hold_tick == 0) ? 1 : longint'(hold_tick);
        climb = pid_command(0, longint'(hold_alt) - longint'(a), dt);
        accel = pid_command(1, longint'(hold_spd) - longint'(s), dt);
        // shortest way round, within half a turn
        herr = longint'(hold_hdg) - longint'(h) + HDG_FULL + HDG_HALF;
        herr = herr - floor_quot(herr, HDG_FULL) * HDG_FULL - HDG_HALF;
        turn = pid_command(2, herr, dt);
        fresh_loops = 1'b0;
        na = clip(longint'(a) + nearest_quot(climb * dt, ALT_DIV), 0, ALT_MAX);
        ns = clip(longint'(s) + nearest_quot(accel * dt, 1024), 0, SPD_MAX);
        nh = longint'(h) + nearest_quot(turn * dt, 1024);
        nh = nh - floor_quot(nh, HDG_FULL) * HDG_FULL;
        r.climb = climb[CLIMB_W-1:0];
        r.accel = accel[ACCEL_W-1:0];
        r.turn = turn[TURN_W-1:0];
        r.alt = na[ALT_W-1:0];
        r.spd = ns[SPD_W-1:0];
        r.hdg = nh[HDG_W-1:0];
        r.active = 1'b1;
        return r;
    endfunction

    // Wait until every expected item has come back
    task automatic wait_drained();
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    // Register write; valid stays high across back-to-back writes
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge aclk); while (!cfg_ready);
        apply_write(idx, data);
    endtask

    task automatic end_writes();
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Offer one measurement item, with random idle cycles ahead of it unless calm
    task automatic send_tick(input logic [ALT_W-1:0] a, input logic [SPD_W-1:0] s,
                             input logic [HDG_W-1:0] h, input bit typed,
                             input hold_result_t want);
        hold_result_t r;
        @(negedge aclk);
        while (!calm && $urandom_range(0, 99) < 15) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_measured_altitude = a;
        s_measured_speed = s;
        s_measured_heading = h;
        do @(posedge aclk); while (!s_ready);
        r = predict_tick(a, s, h);
        expected_results.push_back(typed ? want : r);
    endtask

    task automatic idle_sender();
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        script_row_t row;
        row = '0;
        row.is_write = 1'b1;
        row.idx = idx;
        row.data = data;
        script.push_back(row);
    endfunction

    function automatic void add_tick(input logic [ALT_W-1:0] a, input logic [SPD_W-1:0] s,
                                     input logic [HDG_W-1:0] h, input bit typed);
        script_row_t row;
        row = '0;
        row.alt = a;
        row.spd = s;
        row.hdg = h;
        row.typed = typed;
        // typed rows run disengaged: commands zero, values pass through
        row.want.alt = a;
        row.want.spd = s;
        row.want.hdg = h;
        script.push_back(row);
    endfunction

    // Random value near a setpoint, or anywhere in range, or anywhere in the field
    function automatic longint near_or_wide(input longint tgt, input int span,
                                            input longint top, input int w);
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 7)
            return clip(tgt + $urandom_range(0, 2 * span) - span, 0, (64'd1 << w) - 1);
        if (mode < 9)
            return $urandom_range(0, top);
        return $urandom_range(0, (1 << w) - 1);
    endfunction

    // Check every result item against the oldest expectation
    initial begin
        hold_result_t want;
        int stall_left;
        bit stalled;
        stall_left = 0;
        stalled = 1'b0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("result item with no expectation waiting");
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_climb_command !== want.climb) begin
                        $error("climb_command: expected %0d, got %0d", want.climb,
                               m_climb_command);
                        fail_count++;
                    end
                    if (m_accel_command !== want.accel) begin
                        $error("accel_command: expected %0d, got %0d", want.accel,
                               m_accel_command);
                        fail_count++;
                    end
                    if (m_turn_command !== want.turn) begin
                        $error("turn_command: expected %0d, got %0d", want.turn,
                               m_turn_command);
                        fail_count++;
                    end
                    if (m_next_altitude !== want.alt) begin
                        $error("next_altitude: expected %0d, got %0d", want.alt,
                               m_next_altitude);
                        fail_count++;
                    end
                    if (m_next_speed !== want.spd) begin
                        $error("next_speed: expected %0d, got %0d", want.spd, m_next_speed);
                        fail_count++;
                    end
                    if (m_next_heading !== want.hdg) begin
                        $error("next_heading: expected %0d, got %0d", want.hdg,
                               m_next_heading);
                        fail_count++;
                    end
                    if (m_loops_active !== want.active) begin
                        $error("loops_active: expected %0d, got %0d", want.active,
                               m_loops_active);
                        fail_count++;
                    end
                end
            end
            @(negedge aclk);
            // hold off once for a long stretch so the block backs up
            if (!stalled && results_seen >= 300) begin
                stalled = 1'b1;
                stall_left = STALL_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready = 1'b0;
            end else begin
                m_ready = calm ? 1'b1 : ($urandom_range(0, 99) >= 15);
            end
        end
    end

    // Watchdog on cycles with no item moving on any channel
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
                || !run_started)
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("three_axis_pid_hold_controller test failed");
                $finish;
            end
        end
    end

    initial begin
        script_row_t row;
        hold_result_t none;
        logic [CFG_DATA_W-1:0] t_alt, t_spd, t_hdg, t_tick;
        longint a, s, h;

        fail_count = 0;
        results_seen = 0;
        calm = 1'b0;
        run_started = 1'b0;
        none = '0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_measured_altitude = '0;
        s_measured_speed = '0;
        s_measured_heading = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hold_alt = '0;
        hold_spd = '0;
        hold_hdg = '0;
        hold_tick = TICK_RESET;
        hold_engaged = 1'b0;
        clear_loops();

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        run_started = 1'b1;

        // Directed: disengaged pass-through, then extremes with loops running
        add_tick(20'd0, 13'd0, 15'd0, 1'b1);
        add_tick(20'd800000, 13'd8000, 15'd23039, 1'b1);
        add_tick(20'hFFFFF, 13'h1FFF, 15'h7FFF, 1'b1);
        add_tick(20'h55555, 13'h0AAA, 15'h2AAA, 1'b1);
        add_write(CFG_ENG, 20'd1);
        add_tick(20'd0, 13'd0, 15'd0, 1'b0);
        add_tick(20'd800000, 13'd8000, 15'd23039, 1'b0);
        add_tick(20'd400000, 13'd4000, 15'd11520, 1'b0);
        add_write(CFG_TALT, 20'd800000);
        add_write(CFG_TSPD, 20'd8000);
        add_write(CFG_THDG, 20'd23039);
        add_tick(20'd0, 13'd0, 15'd0, 1'b0);
        add_tick(20'd0, 13'd0, 15'd0, 1'b0);
        add_tick(20'd800000, 13'd8000, 15'd0, 1'b0);
        add_tick(20'hFFFFF, 13'h1FFF, 15'h7FFF, 1'b0);
        add_write(CFG_TICK, 20'd0);
        add_tick(20'd799000, 13'd7990, 15'd23000, 1'b0);
        add_tick(20'd799500, 13'd7995, 15'd23030, 1'b0);
        add_write(CFG_TICK, 20'd4096);
        add_tick(20'd0, 13'd0, 15'd100, 1'b0);
        add_tick(20'd10, 13'd5, 15'd200, 1'b0);
        add_write(CFG_THDG, 20'd0);
        add_tick(20'd800000, 13'd8000, 15'd11520, 1'b0);
        add_tick(20'd800000, 13'd8000, 15'd11519, 1'b0);
        add_tick(20'd800000, 13'd8000, 15'd11521, 1'b0);
        add_write(3'd5, 20'hABCDE);
        add_tick(20'd800000, 13'd8000, 15'd23039, 1'b0);
        add_tick(20'd799999, 13'd7999, 15'd1, 1'b0);

        // Walk the script; writes only once all expected items are back
        foreach (script[i]) begin
            row = script[i];
            if (row.is_write) begin
                idle_sender();
                wait_drained();
                write_reg(row.idx, row.data);
                if (i + 1 < script.size() && !script[i + 1].is_write) end_writes();
            end else begin
                send_tick(row.alt, row.spd, row.hdg, row.typed, row.want);
            end
        end

        // Random phases, each with its own setpoints and tick
        for (int p = 0; p < PHASES; p++) begin
            idle_sender();
            wait_drained();
            case (p)
                1: begin t_alt = 800000; t_spd = 8000; t_hdg = 23039; t_tick = 4096; end
                2: begin t_alt = 0; t_spd = 0; t_hdg = 0; t_tick = 1; end
                3: begin t_alt = $urandom_range(0, 800000); t_spd = $urandom_range(0, 8000);
                         t_hdg = $urandom_range(0, 23039); t_tick = 0; end
                4: begin t_alt = $urandom_range(0, 800000); t_spd = $urandom_range(0, 8000);
                         t_hdg = $urandom_range(0, 23039); t_tick = 8191; end
                5: begin t_alt = 20'hFFFFF; t_spd = 13'h1FFF; t_hdg = 15'h7FFF;
                         t_tick = $urandom_range(1, 4096); end
                default: begin
                    t_alt = $urandom_range(0, 800000); t_spd = $urandom_range(0, 8000);
                    t_hdg = $urandom_range(0, 23039);
                    t_tick = (p == 0) ? 1024 : $urandom_range(1, 4096);
                end
            endcase
            write_reg(CFG_TALT, t_alt);
            write_reg(CFG_TSPD, t_spd);
            write_reg(CFG_THDG, t_hdg);
            write_reg(CFG_TICK, t_tick);
            write_reg(CFG_ENG, (p == 6) ? 20'd0 : 20'd1);
            end_writes();
            calm = (p == 3);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // unused index mid-phase must leave loop state alone
                if (n == 50) begin
                    idle_sender();
                    wait_drained();
                    write_reg(CFG_IDX_W'(5 + p % 3), CFG_DATA_W'($urandom()));
                    end_writes();
                end
                a = near_or_wide(longint'(hold_alt), 4000, ALT_MAX, ALT_W);
                s = near_or_wide(longint'(hold_spd), 200, SPD_MAX, SPD_W);
                h = near_or_wide(longint'(hold_hdg), 3000, HDG_FULL - 1, HDG_W);
                send_tick(a[ALT_W-1:0], s[SPD_W-1:0], h[HDG_W-1:0], 1'b0, none);
            end
            calm = 1'b0;
        end

        idle_sender();
        wait_drained();
        repeat (500) @(posedge aclk);
        if (fail_count == 0 && expected_results.size() == 0)
            $display("three_axis_pid_hold_controller test passed");
        else
            $display("three_axis_pid_hold_controller test failed");
        $finish;
    end

endmodule
